### hdl/wzq_pkg.sv
// shared types and constants of the window z-score quantizer
package wzq_pkg;

    localparam int CFG_WIDTH = 16;
    localparam int IDX_WIDTH = 1;

    localparam logic [IDX_WIDTH-1:0] REG_INV_SCALE  = 1'b0;
    localparam logic [IDX_WIDTH-1:0] REG_ZERO_POINT = 1'b1;

    localparam logic [15:0] INV_SCALE_RESET  = 16'd8470;
    localparam logic [7:0]  ZERO_POINT_RESET = 8'd116;

    // quotient cap before the zero point is added
    localparam int Q_CAP = 1024;

    // controller to datapath commands
    typedef struct packed {
        logic store;      // write accepted sample, update sums
        logic sqrt_start; // load variance into square root unit
        logic sqrt_step;  // one square root iteration
        logic rd_start;   // read first stored sample
        logic div_start;  // load numerator and divisor for one sample
        logic div_step;   // one restoring division step
        logic out_load;   // form code into output register
        logic clear;      // clear sums for the next window
    } wzq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic full;       // window is full after this store
        logic sqrt_done;
        logic div_done;
        logic last_item;  // current read address is the final one
    } wzq_sts_t;

endpackage

### hdl/wzq_datapath.sv
// datapath: sample store, running sums, square root and divider units
module wzq_datapath
    import wzq_pkg::*;
#(
    parameter int WINDOW      = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wzq_cmd_t               cmd,
    output wzq_sts_t               sts,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic [15:0]            inv_scale,
    input  logic [7:0]             zero_point,
    output logic [7:0]             code_out
);
    localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW     = $clog2(WINDOW + 1);
    localparam int SUMW   = SAMPLE_BITS + CW;
    localparam int SQW    = 2 * SAMPLE_BITS + CW;
    localparam int VW     = SQW + CW + 1;
    localparam int RW     = (VW + 1) / 2;
    localparam int SQ_IT  = RW;
    localparam int DW     = SUMW + 1;
    localparam int NUMW   = DW + 16 + 1;
    localparam int DENW   = RW + 9;
    localparam int QW     = NUMW;
    localparam int DIV_IT = NUMW;
    localparam int SQCW   = $clog2(SQ_IT + 1);
    localparam int DVCW   = $clog2(DIV_IT + 1);

    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [AW-1:0]          wr_addr_reg, wr_addr_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [SUMW-1:0]        sum_reg, sum_next;
    logic [SQW-1:0]         sq_reg, sq_next;

    // square root state, an even number of bits so pairs line up
    logic [2*RW-1:0] rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [SQCW-1:0] sq_cnt_reg, sq_cnt_next;

    // divider state
    logic [NUMW-1:0] dnum_reg, dnum_next;
    logic [DENW:0]   drem_reg, drem_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [DVCW-1:0] dv_cnt_reg, dv_cnt_next;
    logic            neg_reg, neg_next;
    logic [7:0]      code_reg, code_next;
    logic [NUMW-1:0] prod_reg, prod_next;

    logic [VW-1:0]     nq, ss, var_w;
    logic [SUMW+CW:0]  nx;
    logic [DW-1:0]     mag;
    logic              neg_w;
    logic [DENW:0]     den2;
    logic [DENW+1:0]   trial;
    logic [RW+1:0]     sq_acc;
    logic [RW+1:0]     sq_tq;
    logic [1:0]        pair;
    logic [QW-1:0]     qsat;
    logic signed [QW+1:0] vsum;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[wr_addr_reg] <= sample_in;
        end
        rd_data_reg <= mem[rd_addr_next];
    end

    always_comb
    begin
        nq    = VW'(sq_reg) * VW'(WINDOW);
        ss    = VW'(sum_reg) * VW'(sum_reg);
        var_w = (nq > ss) ? nq - ss : '0;
    end

    // digit-by-digit square root, one result bit per step
    always_comb
    begin
        pair     = rem_reg[2*RW-1 -: 2];
        sq_acc   = {prod_reg[RW-1:0], pair};
        sq_tq    = {root_reg, 2'b01};
        rem_next    = rem_reg;
        root_next   = root_reg;
        sq_cnt_next = sq_cnt_reg;
        if (cmd.sqrt_start)
        begin
            rem_next    = (2*RW)'(var_w);
            root_next   = '0;
            sq_cnt_next = SQCW'(SQ_IT);
        end
        else if (cmd.sqrt_step)
        begin
            sq_cnt_next = sq_cnt_reg - 1'b1;
            rem_next    = {rem_reg[2*RW-3:0], 2'b00};
            root_next   = {root_reg[RW-2:0], 1'b0};
            if (sq_acc >= sq_tq)
            begin
                root_next = {root_reg[RW-2:0], 1'b1};
            end
        end
    end

    // prod_reg doubles as the partial square root remainder during the root phase
    always_comb
    begin
        nx    = (SUMW+CW+1)'(rd_data_reg) * (SUMW+CW+1)'(WINDOW);
        neg_w = nx < (SUMW+CW+1)'(sum_reg);
        mag   = neg_w ? DW'((SUMW+CW+1)'(sum_reg) - nx)
                      : DW'(nx - (SUMW+CW+1)'(sum_reg));
        den2  = {root_reg, 9'd0} + (DENW+1)'(0);
        trial = {drem_reg, dnum_reg[NUMW-1]} - (DENW+2)'(den2);
        prod_next  = prod_reg;
        dnum_next  = dnum_reg;
        drem_next  = drem_reg;
        quo_next   = quo_reg;
        dv_cnt_next = dv_cnt_reg;
        neg_next   = neg_reg;
        if (cmd.sqrt_start)
        begin
            prod_next = '0;
        end
        else if (cmd.sqrt_step)
        begin
            prod_next = NUMW'(sq_acc);
            if (sq_acc >= sq_tq)
            begin
                prod_next = NUMW'(sq_acc - sq_tq);
            end
        end
        else if (cmd.div_start)
        begin
            // 2*|num| + den, divided later by 2*den
            dnum_next   = NUMW'({(NUMW-1)'(mag) * (NUMW-1)'(inv_scale), 1'b0}) +
                          NUMW'({root_reg, 8'd0});
            drem_next   = '0;
            quo_next    = '0;
            dv_cnt_next = DVCW'(DIV_IT);
            neg_next    = neg_w;
        end
        else if (cmd.div_step)
        begin
            dv_cnt_next = dv_cnt_reg - 1'b1;
            dnum_next   = {dnum_reg[NUMW-2:0], 1'b0};
            if (!trial[DENW+1])
            begin
                drem_next = trial[DENW:0];
                quo_next  = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                drem_next = {drem_reg[DENW-1:0], dnum_reg[NUMW-1]};
                quo_next  = {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        qsat = (quo_reg > QW'(Q_CAP)) ? QW'(Q_CAP) : quo_reg;
        vsum = neg_reg ? (QW+2)'(signed'({1'b0, zero_point})) - signed'((QW+2)'(qsat))
                       : (QW+2)'(signed'({1'b0, zero_point})) + signed'((QW+2)'(qsat));
        code_next = code_reg;
        if (cmd.out_load)
        begin
            if (root_reg == '0)
                code_next = zero_point;
            else if (vsum < 0)
                code_next = 8'd0;
            else if (vsum > 255)
                code_next = 8'd255;
            else
                code_next = vsum[7:0];
        end
    end

    always_comb
    begin
        wr_addr_next = wr_addr_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        rd_addr_next = rd_addr_reg;
        if (cmd.clear)
        begin
            sum_next     = '0;
            sq_next      = '0;
            wr_addr_next = '0;
        end
        else if (cmd.store)
        begin
            sum_next     = sum_reg + SUMW'(sample_in);
            sq_next      = sq_reg + SQW'(sample_in) * SQW'(sample_in);
            wr_addr_next = (wr_addr_reg == AW'(WINDOW-1)) ? '0 : wr_addr_reg + 1'b1;
        end
        if (cmd.rd_start)
            rd_addr_next = '0;
        else if (cmd.out_load)
            rd_addr_next = (rd_addr_reg == AW'(WINDOW-1)) ? '0 : rd_addr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_addr_reg <= '0;
            rd_addr_reg <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            sq_cnt_reg  <= '0;
            dv_cnt_reg  <= '0;
        end
        else
        begin
            wr_addr_reg <= wr_addr_next;
            rd_addr_reg <= rd_addr_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            sq_cnt_reg  <= sq_cnt_next;
            dv_cnt_reg  <= dv_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        prod_reg <= prod_next;
        dnum_reg <= dnum_next;
        drem_reg <= drem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        code_reg <= code_next;
    end

    assign sts.full      = (wr_addr_reg == AW'(WINDOW-1));
    assign sts.sqrt_done = (sq_cnt_reg == SQCW'(1));
    assign sts.div_done  = (dv_cnt_reg == DVCW'(1));
    assign sts.last_item = (rd_addr_reg == AW'(WINDOW-1));
    assign code_out      = code_reg;

endmodule

### hdl/wzq_ctrl.sv
// controller: sequences collection, square root, per-item division and output
module wzq_ctrl
    import wzq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     out_last,
    output wzq_cmd_t cmd,
    input  wzq_sts_t sts
);
    typedef enum logic [7:0] {
        S_COLLECT = 8'b00000001,
        S_PREP    = 8'b00000010,
        S_SQRT    = 8'b00000100,
        S_READ    = 8'b00001000,
        S_LOAD    = 8'b00010000,
        S_DIV     = 8'b00100000,
        S_FORM    = 8'b01000000,
        S_EMIT    = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (sts.full)
                    begin
                        state_next = S_PREP;
                        cmd.clear  = 1'b0;
                    end
                end
            end
            S_PREP:
            begin
                // sums now hold the whole window, load the variance
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_FORM;
            end
            S_FORM:
            begin
                cmd.out_load = 1'b1;
                last_next    = sts.last_item;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
        if (state_reg == S_SQRT && state_next == S_READ)
            cmd.rd_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    assign out_last = last_reg;

endmodule

### hdl/window_zscore_quantizer.sv
// top level of the window z-score quantizer
// Collects WINDOW samples, one per cycle, while running sums grow; once the
// window is full the variance is loaded and a digit-serial square root
// (20 steps at the default sizes) finds the deviation, then each stored sample
// goes through a bit-serial restoring divider (37 steps at the default sizes)
// and leaves as one code, which an output stall may hold back; no new
// sample is taken until the last code of the window has been delivered.
module window_zscore_quantizer
    import wzq_pkg::*;
#(
    parameter int WINDOW      = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [11:0]          sample,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           code,
    output logic                 last
);
    logic [15:0] inv_scale_reg;
    logic [7:0]  zero_point_reg;
    wzq_cmd_t    cmd;
    wzq_sts_t    sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_scale_reg  <= INV_SCALE_RESET;
            zero_point_reg <= ZERO_POINT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INV_SCALE:  inv_scale_reg  <= cfg_data;
                REG_ZERO_POINT: zero_point_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    wzq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (last),
        .cmd       (cmd),
        .sts       (sts)
    );

    wzq_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .sample_in  (sample[SAMPLE_BITS-1:0]),
        .inv_scale  (inv_scale_reg),
        .zero_point (zero_point_reg),
        .code_out   (code)
    );

endmodule

### hdl/wzq_checker.sv
// port-level checker for the window z-score quantizer, bound to the top level
module wzq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] code,
    input logic       last
);
    // no sample is taken while a code is on offer
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input ready while output valid");

    // a stalled item holds its code and flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code) && $stable(last))
        else $error("output item changed while stalled");

    // after the final code the block goes back to collecting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> in_ready)
        else $error("not collecting after last item");

    // taking an input never produces a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result right after input");
endmodule

bind window_zscore_quantizer wzq_checker u_wzq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code      (code),
    .last      (last)
);

### verif/window_zscore_quantizer_tb.sv
// self-checking testbench for the window z-score quantizer
`timescale 1ns / 1ps

module window_zscore_quantizer_tb;
    import wzq_pkg::*;

    localparam int WIN = 64;
    localparam int IDLE_LIMIT = 20000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [IDX_WIDTH-1:0] cfg_index = REG_INV_SCALE;
    logic [CFG_WIDTH-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [11:0]          sample = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           code;
    logic                 last;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } code_item_t;

    logic [11:0]  pending_samples[$];
    code_item_t   expected_codes[$];

    // predictor state
    logic [15:0] pred_inv_scale = INV_SCALE_RESET;
    logic [7:0]  pred_zero_point = ZERO_POINT_RESET;
    logic [11:0] pred_window[WIN];
    int          pred_fill = 0;
    longint      pred_sum = 0;
    longint      pred_sq_sum = 0;

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_off = 0;
    bit  long_hold_req = 1'b0;

    window_zscore_quantizer dut (.*);

    always #5 clk = ~clk;

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] quantize_sample(logic [11:0] x, longint root);
        longint nx;
        longint mag;
        longint num;
        longint den;
        longint q;
        longint v;
        bit     neg;
        if (root == 0)
            return pred_zero_point;
        nx = WIN * longint'(x);
        neg = nx < pred_sum;
        mag = neg ? pred_sum - nx : nx - pred_sum;
        num = mag * longint'(pred_inv_scale);
        den = root * 256;
        q = (2 * num + den) / (2 * den);
        if (q > Q_CAP) q = Q_CAP;
        v = longint'(pred_zero_point) + (neg ? -q : q);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    task automatic accept_sample(logic [11:0] x);
        longint var_n;
        longint root;
        code_item_t c;
        pred_window[pred_fill] = x;
        pred_sum += x;
        pred_sq_sum += longint'(x) * longint'(x);
        pred_fill++;
        if (pred_fill == WIN)
        begin
            var_n = WIN * pred_sq_sum - pred_sum * pred_sum;
            if (var_n < 0) var_n = 0;
            root = int_sqrt(var_n);
            for (int i = 0; i < WIN; i++)
            begin
                c.code = quantize_sample(pred_window[i], root);
                c.last = (i == WIN - 1);
                expected_codes.push_back(c);
            end
            pred_fill = 0;
            pred_sum = 0;
            pred_sq_sum = 0;
        end
    endtask

    task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INV_SCALE)
            pred_inv_scale = val;
        else
            pred_zero_point = val[7:0];
    endtask

    task automatic queue_window(int kind);
        logic [11:0] base;
        base = 12'($urandom_range(0, 4095));
        for (int i = 0; i < WIN; i++)
        begin
            case (kind)
                0: pending_samples.push_back(12'($urandom));
                1: pending_samples.push_back(base);
                2: pending_samples.push_back((i == 5) ? 12'hFFF : 12'h000);
                3: pending_samples.push_back(i[0] ? 12'hFFF : 12'h000);
                default: pending_samples.push_back(
                    12'(int'(base) + $urandom_range(0, 15)));
            endcase
        end
    endtask

    task automatic drain;
        while (pending_samples.size() != 0 || expected_codes.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // driver: bursts with random gaps
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            accept_sample(sample);
            void'(pending_samples.pop_front());
        end
        if (!(in_valid && !in_ready))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                in_valid <= 1'b1;
                sample <= pending_samples[0];
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_codes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected code %0d last %0b", code, last);
            end
            else
            begin
                code_item_t e;
                e = expected_codes.pop_front();
                if (e.code !== code || e.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("code mismatch: expected %0d/%0b got %0d/%0b",
                                 e.code, e.last, code, last);
                end
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (long_hold_req)
        begin
            // long stall so the block fills and blocks its input
            long_hold_req <= 1'b0;
            hold_off <= 800;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 3000) == 0)
        begin
            hold_off <= 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 7) < (($time / 40000) % 2 ? 8 : 5));
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // directed: reset settings, then extremes and special cases
        queue_window(3);
        queue_window(1);
        pending_samples.push_back(12'h123);   // partial window carried over
        drain();
        write_reg(REG_INV_SCALE, 16'hFFFF);
        write_reg(REG_ZERO_POINT, 16'd0);
        for (int i = 0; i < WIN - 1; i++) pending_samples.push_back(12'($urandom));
        queue_window(2);
        drain();
        write_reg(REG_INV_SCALE, 16'd0);
        write_reg(REG_ZERO_POINT, 16'd255);
        queue_window(0);
        drain();
        // hold the receiver off while the sender keeps offering items
        write_reg(REG_INV_SCALE, 16'($urandom_range(1, 65535)));
        write_reg(REG_ZERO_POINT, 16'($urandom_range(0, 255)));
        queue_window(4);
        for (int i = 0; i < 8; i++) pending_samples.push_back(12'($urandom));
        @(posedge clk);
        long_hold_req = 1'b1;
        drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
